[rtl/core/sbs_pkg.sv]
// Shared constants and types of the sketch bitmap store.
package sbs_pkg;

  localparam int SKETCH_BITS  = 32;
  localparam int MAX_SKETCHES = 64;

  localparam int SK_AW      = (MAX_SKETCHES > 1) ? $clog2(MAX_SKETCHES) : 1;
  localparam int FIELD_IDX_W = 6;
  localparam int CNT_W      = 6;
  localparam int CNT_FULL_W = $clog2(SKETCH_BITS + 1);
  localparam int CFG_W      = 7;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CFG_W-1:0]    SKETCHES_RESET = CFG_W'(64);
  localparam logic [APB_AW-1:0]   ADDR_SKETCHES_IN_USE = APB_AW'(0);

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SKETCH = 2'd1,
    ERR_BIT    = 2'd2
  } err_t;

  typedef logic [SKETCH_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]       cnt_t;

endpackage

[rtl/core/sbs_count.sv]
// Leading-ones and trailing-zeros counter for one sketch word.
module sbs_count
  import sbs_pkg::*;
(
  input  word_t word,
  output cnt_t  leading_ones,
  output cnt_t  trailing_zeros
);

  function automatic logic [CNT_FULL_W-1:0] tz_count(input word_t w);
    word_t                 onehot;
    logic [CNT_FULL_W-1:0] idx;
    onehot = w & (~w + SKETCH_BITS'(1));
    idx = '0;
    for (int k = 0; k < SKETCH_BITS; k++) begin
      if (onehot[k]) begin
        idx = idx | CNT_FULL_W'(k);
      end
    end
    if (w == '0) begin
      idx = CNT_FULL_W'(SKETCH_BITS);
    end
    return idx;
  endfunction

  function automatic cnt_t sat(input logic [CNT_FULL_W-1:0] v);
    if (v > CNT_FULL_W'((1 << CNT_W) - 1)) begin
      return cnt_t'((1 << CNT_W) - 1);
    end
    return v[CNT_W-1:0];
  endfunction

  word_t rev_inv;

  always_comb begin
    for (int k = 0; k < SKETCH_BITS; k++) begin
      rev_inv[k] = ~word[SKETCH_BITS-1-k];
    end
  end

  assign trailing_zeros = sat(tz_count(word));
  assign leading_ones   = sat(tz_count(rev_inv));

endmodule

[rtl/core/sketch_bitmap_store.sv]
// Top level of the sketch bitmap store: stream ports, register port and sketch memory.
// An accepted transaction latches its sketch word and valid bit on the accept edge;
// in ST_UPDATE it is updated and counted, and the output register is loaded once
// the output is free, so back-pressure on m_tready stalls it there. One transaction
// is in flight at a time: s_tready is low until ST_UPDATE hands its result on.
// Reset clears control state and the per-sketch valid bits at once, so every
// sketch reads as zero right after reset, and sets sketches_in_use to 64.
module sketch_bitmap_store
  import sbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // mode[0], sketch_index[6:1], bit_index[12:7], zero pad
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // leading_ones[5:0], trailing_zeros[11:6],
                                       // error_code[13:12], zero pad
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t state;

  logic [CFG_W-1:0] sketches_in_use;

  word_t mem [MAX_SKETCHES];
  logic [MAX_SKETCHES-1:0] valid;

  logic                   in_mode;
  logic [FIELD_IDX_W-1:0] in_sketch;
  logic [FIELD_IDX_W-1:0] in_bit;
  err_t                   in_err;
  logic                   accept;

  logic                   req_mode;
  logic [SK_AW-1:0]       req_sketch;
  logic [FIELD_IDX_W-1:0] req_bit;
  err_t                   req_err;
  word_t                  rd_word;
  logic                   rd_valid;

  word_t cur_word;
  word_t new_word;
  logic  wr_en;
  logic  out_free;
  cnt_t  lead_cnt;
  cnt_t  trail_cnt;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SKETCHES_IN_USE) ? APB_DW'(sketches_in_use) : '0;

  assign in_mode   = s_tdata[0];
  assign in_sketch = s_tdata[6:1];
  assign in_bit    = s_tdata[12:7];

  always_comb begin
    priority if (32'(in_sketch) >= 32'(sketches_in_use) ||
                 32'(in_sketch) >= 32'(MAX_SKETCHES)) begin
      in_err = ERR_SKETCH;
    end else if (!in_mode && 32'(in_bit) >= 32'(SKETCH_BITS)) begin
      in_err = ERR_BIT;
    end else begin
      in_err = ERR_NONE;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign cur_word = rd_valid ? rd_word : '0;
  assign new_word = req_mode ? cur_word
                             : (cur_word | (SKETCH_BITS'(1) << req_bit));
  assign wr_en    = (state == ST_UPDATE) && (req_err == ERR_NONE) && !req_mode;

  sbs_count u_count (
    .word           (new_word),
    .leading_ones   (lead_cnt),
    .trailing_zeros (trail_cnt)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[req_sketch] <= new_word;
    end
    if (accept) begin
      rd_word    <= mem[in_sketch[SK_AW-1:0]];
      req_mode   <= in_mode;
      req_sketch <= in_sketch[SK_AW-1:0];
      req_bit    <= in_bit;
      req_err    <= in_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      sketches_in_use <= SKETCHES_RESET;
      valid           <= '0;
      rd_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      m_tdata         <= '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_SKETCHES_IN_USE) begin
        sketches_in_use <= pwdata[CFG_W-1:0];
      end
      if (accept) begin
        rd_valid <= valid[in_sketch[SK_AW-1:0]];
      end
      if (wr_en) begin
        valid[req_sketch] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (accept) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (req_err == ERR_NONE) begin
              m_tdata <= OUT_W'({req_err, trail_cnt, lead_cnt});
            end else begin
              m_tdata <= OUT_W'({req_err, cnt_t'(0), cnt_t'(0)});
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[dv/sketch_bitmap_store_test.sv]
// Self-checking stream testbench for the sketch bitmap store with a built-in predictor.
module sketch_bitmap_store_test;
  import sbs_pkg::*;

  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam int   SEGMENTS  = 9;
  localparam int   SEGMENT_ITEMS = 180;

  typedef struct packed {
    logic [1:0] pad;
    err_t       err;
    cnt_t       tz;
    cnt_t       lo;
  } sketch_counts_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic [IN_W-1:0] stream_items[$];
  sketch_counts_t  awaited_counts[$];
  word_t           shadow_bitmaps[MAX_SKETCHES];
  logic [CFG_W-1:0] shadow_limit = SKETCHES_RESET;
  int              items_queued = 0;
  int              items_accepted = 0;
  int              mismatches = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;

  sketch_bitmap_store uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic sketch_counts_t tally_sketch(logic mode, logic [5:0] sk, logic [5:0] bi);
    sketch_counts_t r;
    word_t w;
    int lo;
    int tz;
    int k;
    r = '0;
    r.err = ERR_NONE;
    lo = 0;
    tz = 0;
    if (sk >= shadow_limit || sk >= MAX_SKETCHES) begin
      r.err = ERR_SKETCH;
      return r;
    end
    if (mode == MODE_SET) begin
      if (bi >= SKETCH_BITS) begin
        r.err = ERR_BIT;
        return r;
      end
      shadow_bitmaps[sk][bi] = 1'b1;
    end
    w = shadow_bitmaps[sk];
    for (k = SKETCH_BITS - 1; k >= 0 && w[k]; k--) lo++;
    for (k = 0; k < SKETCH_BITS && !w[k]; k++) tz++;
    r.lo = (lo > 63) ? cnt_t'(63) : cnt_t'(lo);
    r.tz = (tz > 63) ? cnt_t'(63) : cnt_t'(tz);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_counts.push_back(tally_sketch(s_tdata[0], s_tdata[6:1], s_tdata[12:7]));
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (stream_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= stream_items.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    sketch_counts_t want;
    sketch_counts_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = sketch_counts_t'(m_tdata);
        if (awaited_counts.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = awaited_counts.pop_front();
          if (got.lo !== want.lo) begin
            $display("%0t: leading_ones expected %0d actual %0d", $time, want.lo, got.lo);
            mismatches++;
          end
          if (got.tz !== want.tz) begin
            $display("%0t: trailing_zeros expected %0d actual %0d", $time, want.tz, got.tz);
            mismatches++;
          end
          if (got.err !== want.err) begin
            $display("%0t: error_code expected %0d actual %0d", $time, want.err, got.err);
            mismatches++;
          end
          if (got.pad !== want.pad) begin
            $display("%0t: pad bits expected %b actual %b", $time, want.pad, got.pad);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_item(logic mode, logic [5:0] sk, logic [5:0] bi);
    stream_items.push_back({3'b000, bi, sk, mode});
    items_queued++;
  endtask

  task automatic wait_quiet();
    while (items_accepted != items_queued || awaited_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SKETCHES_IN_USE;
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_limit = value;
  endtask

  function automatic logic [5:0] pick_sketch();
    int hot;
    if (shadow_limit != 0 && $urandom_range(1) == 1) begin
      hot = $urandom_range(4);
      if (hot == 4 || hot >= shadow_limit) hot = shadow_limit - 1;
      if (hot > 63) hot = 63;
      return 6'(hot);
    end
    return 6'($urandom_range(63));
  endfunction

  task automatic queue_random(int n);
    int made;
    int pick;
    int top;
    int len;
    int j;
    logic [5:0] sk;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      sk = pick_sketch();
      if (pick < 15) begin
        top = ($urandom_range(1) == 1) ? SKETCH_BITS - 1 : $urandom_range(SKETCH_BITS - 1);
        len = $urandom_range(8, 1);
        for (j = 0; j < len && top - j >= 0; j++) begin
          queue_item(MODE_SET, sk, 6'(top - j));
          made++;
        end
      end else if (pick < 55) begin
        queue_item(MODE_SET, sk, 6'($urandom_range(SKETCH_BITS - 1)));
        made++;
      end else if (pick < 70) begin
        queue_item(MODE_SET, sk, 6'($urandom_range(63, SKETCH_BITS)));
        made++;
      end else begin
        queue_item(MODE_READ, sk, 6'($urandom_range(63)));
        made++;
      end
    end
  endtask

  initial begin
    int seg;
    int i;
    logic [CFG_W-1:0] limits[SEGMENTS];
    limits = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd64, 7'd13, 7'd32, 7'd0, 7'd64};
    limits[7] = CFG_W'($urandom_range(64, 1));
    for (i = 0; i < MAX_SKETCHES; i++) shadow_bitmaps[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (seg == 0) begin
        queue_item(MODE_READ, 6'd0, 6'd63);
        queue_item(MODE_SET, 6'd0, 6'd0);
        queue_item(MODE_SET, 6'd0, 6'd31);
        queue_item(MODE_SET, 6'd63, 6'd31);
        queue_item(MODE_SET, 6'd63, 6'd32);
        queue_item(MODE_SET, 6'd63, 6'd63);
        queue_item(MODE_READ, 6'd63, 6'd63);
        queue_item(MODE_READ, 6'd62, 6'd0);
        queue_item(MODE_SET, 6'd1, 6'd31);
        queue_item(MODE_SET, 6'd1, 6'd30);
        queue_item(MODE_SET, 6'd1, 6'd29);
        queue_item(MODE_SET, 6'd1, 6'd28);
        queue_item(MODE_SET, 6'd2, 6'd1);
        queue_item(MODE_SET, 6'd2, 6'd0);
      end else begin
        write_limit(limits[seg]);
      end
      if (shadow_limit != 0 && shadow_limit <= 64) begin
        queue_item(MODE_READ, 6'(shadow_limit - 1), 6'd42);
        queue_item(MODE_SET, 6'(shadow_limit - 1), 6'($urandom_range(SKETCH_BITS - 1)));
      end
      if (shadow_limit < 64) begin
        queue_item(MODE_READ, 6'(shadow_limit), 6'd0);
        queue_item(MODE_SET, 6'(shadow_limit), 6'd5);
      end
      queue_random(SEGMENT_ITEMS / 2);
      wait_quiet();
      queue_random(SEGMENT_ITEMS / 2);
      wait_quiet();
    end
    if (mismatches == 0 && awaited_counts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
